[sv/prq_pkg.sv]
package prq_pkg;

    localparam int PRIO_LEVELS  = 64;
    localparam int THREAD_SLOTS = 256;

    localparam int LVL_W = $clog2(PRIO_LEVELS);
    localparam int TID_W = $clog2(THREAD_SLOTS);

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 8;
    localparam int MAP_W    = 64;

    typedef logic [LVL_W-1:0]       t_lvl;
    typedef logic [TID_W-1:0]       t_tid;
    typedef logic [PRIO_LEVELS-1:0] t_map;
    typedef logic [OP_W-1:0]        t_op;
    typedef logic [STATUS_W-1:0]    t_status;

    localparam t_op OP_ENQUEUE = 2'd0;
    localparam t_op OP_DEQUEUE = 2'd1;
    localparam t_op OP_REMOVE  = 2'd2;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_EMPTY      = 2'd1;
    localparam t_status ST_NOT_QUEUED = 2'd2;
    localparam t_status ST_ALREADY    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LVL,
        S_THR,
        S_UPD
    } t_state;

    // Read and write commands for the per-level head and tail memories.
    typedef struct packed {
        logic rd_en;
        t_lvl rd_addr;
        t_lvl wr_addr;
        logic head_we;
        t_tid head_d;
        logic tail_we;
        t_tid tail_d;
    } t_lvl_cmd;

    typedef struct packed {
        t_tid head;
        t_tid tail;
    } t_lvl_q;

    // Read and write commands for the per-thread link and level memories.
    typedef struct packed {
        logic rd_en;
        t_tid rd_addr;
        logic next_we;
        t_tid next_addr;
        t_tid next_d;
        logic prev_we;
        t_tid prev_addr;
        t_tid prev_d;
        logic lvl_we;
        t_tid lvl_addr;
        t_lvl lvl_d;
    } t_thr_cmd;

    typedef struct packed {
        t_tid next_link;
        t_tid prev_link;
        t_lvl level;
    } t_thr_q;

    function automatic t_lvl lowest_level(input t_map map);
        t_lvl res;
        res = t_lvl'(PRIO_LEVELS - 1);
        for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
            if (map[i]) begin
                res = t_lvl'(i);
            end
        end
        return res;
    endfunction

    function automatic t_lvl clamp_level(input logic [FIELD_W-1:0] prio);
        if (int'(prio) > PRIO_LEVELS - 1) begin
            return t_lvl'(PRIO_LEVELS - 1);
        end
        return t_lvl'(prio);
    endfunction

endpackage

[sv/prq_level_mem.sv]
module prq_level_mem (
    input  logic              i_clk,
    input  prq_pkg::t_lvl_cmd i_cmd,
    output prq_pkg::t_lvl_q   o_q
);

    prq_pkg::t_tid r_head [prq_pkg::PRIO_LEVELS];
    prq_pkg::t_tid r_tail [prq_pkg::PRIO_LEVELS];
    prq_pkg::t_tid r_head_q;
    prq_pkg::t_tid r_tail_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.head_we) begin
            r_head[i_cmd.wr_addr] <= i_cmd.head_d;
        end
        if (i_cmd.tail_we) begin
            r_tail[i_cmd.wr_addr] <= i_cmd.tail_d;
        end
    end

    // Read data holds until the next read so later states can still use it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_head_q <= r_head[i_cmd.rd_addr];
            r_tail_q <= r_tail[i_cmd.rd_addr];
        end
    end

    assign o_q.head = r_head_q;
    assign o_q.tail = r_tail_q;

endmodule

[sv/prq_thread_mem.sv]
module prq_thread_mem (
    input  logic              i_clk,
    input  prq_pkg::t_thr_cmd i_cmd,
    output prq_pkg::t_thr_q   o_q
);

    prq_pkg::t_tid r_next  [prq_pkg::THREAD_SLOTS];
    prq_pkg::t_tid r_prev  [prq_pkg::THREAD_SLOTS];
    prq_pkg::t_lvl r_level [prq_pkg::THREAD_SLOTS];
    prq_pkg::t_tid r_next_q;
    prq_pkg::t_tid r_prev_q;
    prq_pkg::t_lvl r_level_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.next_we) begin
            r_next[i_cmd.next_addr] <= i_cmd.next_d;
        end
        if (i_cmd.prev_we) begin
            r_prev[i_cmd.prev_addr] <= i_cmd.prev_d;
        end
        if (i_cmd.lvl_we) begin
            r_level[i_cmd.lvl_addr] <= i_cmd.lvl_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_next_q  <= r_next[i_cmd.rd_addr];
            r_prev_q  <= r_prev[i_cmd.rd_addr];
            r_level_q <= r_level[i_cmd.rd_addr];
        end
    end

    assign o_q.next_link = r_next_q;
    assign o_q.prev_link = r_prev_q;
    assign o_q.level     = r_level_q;

endmodule

[sv/priority_bitmap_ready_queue.sv]
// Ready queue of thread numbers with one FIFO per priority level.
// Input channel: i_in_valid / o_in_stall carry one command item (i_opcode,
// i_thread_id, i_priority_req). Output channel: o_out_valid / i_out_stall
// carry one result item per command (o_next_thread, o_status,
// o_levels_nonempty). An item moves on an edge with valid high, stall low.
// The block works on one command at a time. An enqueue reads the head/tail
// memory and then writes back; a dequeue reads the head/tail memory, then
// the link memory, then writes back; a remove reads the link memory, then
// the head/tail memory, then writes back; a rejected or unused command goes
// straight to write-back. The result is registered: write-back loads it
// into the output register, and only then is the next command accepted.
// A result waiting in the output register does not block acceptance; a
// further command finishes its reads and then waits at write-back while the
// receiver stalls, holding o_in_stall high.
// Reset clears the level bitmap and all queued marks at once; the link
// memories need no clearing, as only queued entries are ever read.
module priority_bitmap_ready_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_thread_id,
    input  logic [7:0]  i_priority_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_next_thread,
    output logic [1:0]  o_status,
    output logic [63:0] o_levels_nonempty
);

    prq_pkg::t_state  r_state, n_state;
    prq_pkg::t_op     r_op, n_op;
    prq_pkg::t_tid    r_t, n_t;
    prq_pkg::t_lvl    r_lvl, n_lvl;
    prq_pkg::t_status r_status, n_status;
    logic             r_skip, n_skip;
    prq_pkg::t_map    r_bitmap, n_bitmap;
    logic [prq_pkg::THREAD_SLOTS-1:0] r_queued, n_queued;

    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_next, n_out_next;
    prq_pkg::t_status r_out_status, n_out_status;
    prq_pkg::t_map    r_out_map, n_out_map;

    prq_pkg::t_lvl_cmd lvl_cmd;
    prq_pkg::t_lvl_q   lvl_q;
    prq_pkg::t_thr_cmd thr_cmd;
    prq_pkg::t_thr_q   thr_q;

    logic          in_acc;
    logic          out_free;
    logic          tid_ok;
    prq_pkg::t_tid in_tid;
    prq_pkg::t_map lvl_mask;

    prq_level_mem u_level_mem (
        .i_clk (i_clk),
        .i_cmd (lvl_cmd),
        .o_q   (lvl_q)
    );

    prq_thread_mem u_thread_mem (
        .i_clk (i_clk),
        .i_cmd (thr_cmd),
        .o_q   (thr_q)
    );

    assign o_in_stall = (r_state != prq_pkg::S_IDLE);
    assign in_acc     = i_in_valid && (r_state == prq_pkg::S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign tid_ok     = int'(i_thread_id) < prq_pkg::THREAD_SLOTS;
    assign in_tid     = prq_pkg::t_tid'(i_thread_id);
    assign lvl_mask   = prq_pkg::t_map'(1) << r_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prq_pkg::S_IDLE;
            r_bitmap    <= '0;
            r_queued    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bitmap    <= n_bitmap;
            r_queued    <= n_queued;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_t          <= n_t;
        r_lvl        <= n_lvl;
        r_status     <= n_status;
        r_skip       <= n_skip;
        r_out_next   <= n_out_next;
        r_out_status <= n_out_status;
        r_out_map    <= n_out_map;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_t          = r_t;
        n_lvl        = r_lvl;
        n_status     = r_status;
        n_skip       = r_skip;
        n_bitmap     = r_bitmap;
        n_queued     = r_queued;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_next   = r_out_next;
        n_out_status = r_out_status;
        n_out_map    = r_out_map;
        lvl_cmd      = '0;
        thr_cmd      = '0;

        case (r_state)
            prq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op     = i_opcode;
                    n_t      = in_tid;
                    n_status = prq_pkg::ST_OK;
                    n_skip   = 1'b1;
                    n_state  = prq_pkg::S_UPD;
                    case (i_opcode)
                        prq_pkg::OP_ENQUEUE: begin
                            if (!tid_ok) begin
                                n_status = prq_pkg::ST_NOT_QUEUED;
                            end else if (r_queued[in_tid]) begin
                                n_status = prq_pkg::ST_ALREADY;
                            end else begin
                                n_lvl   = prq_pkg::clamp_level(i_priority_req);
                                n_skip  = 1'b0;
                                n_state = prq_pkg::S_LVL;
                            end
                        end
                        prq_pkg::OP_DEQUEUE: begin
                            if (r_bitmap == '0) begin
                                n_status = prq_pkg::ST_EMPTY;
                            end else begin
                                n_lvl   = prq_pkg::lowest_level(r_bitmap);
                                n_skip  = 1'b0;
                                n_state = prq_pkg::S_LVL;
                            end
                        end
                        prq_pkg::OP_REMOVE: begin
                            if (!tid_ok || !r_queued[in_tid]) begin
                                n_status = prq_pkg::ST_NOT_QUEUED;
                            end else begin
                                n_skip  = 1'b0;
                                n_state = prq_pkg::S_THR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            prq_pkg::S_LVL: begin
                // A remove learns its level from the thread memory read.
                lvl_cmd.rd_en = 1'b1;
                if (r_op == prq_pkg::OP_REMOVE) begin
                    lvl_cmd.rd_addr = thr_q.level;
                    n_lvl           = thr_q.level;
                end else begin
                    lvl_cmd.rd_addr = r_lvl;
                end
                n_state = (r_op == prq_pkg::OP_DEQUEUE) ? prq_pkg::S_THR : prq_pkg::S_UPD;
            end

            prq_pkg::S_THR: begin
                thr_cmd.rd_en = 1'b1;
                if (r_op == prq_pkg::OP_DEQUEUE) begin
                    thr_cmd.rd_addr = lvl_q.head;
                    n_t             = lvl_q.head;
                end else begin
                    thr_cmd.rd_addr = r_t;
                end
                n_state = (r_op == prq_pkg::OP_REMOVE) ? prq_pkg::S_LVL : prq_pkg::S_UPD;
            end

            prq_pkg::S_UPD: begin
                if (out_free) begin
                    lvl_cmd.wr_addr = r_lvl;
                    if (!r_skip) begin
                        if (r_op == prq_pkg::OP_ENQUEUE) begin
                            // The tail's next link and the head's prev link are
                            // never read, so a new item leaves them as they are.
                            if (r_bitmap[r_lvl]) begin
                                thr_cmd.next_we   = 1'b1;
                                thr_cmd.next_addr = lvl_q.tail;
                                thr_cmd.next_d    = r_t;
                                thr_cmd.prev_we   = 1'b1;
                                thr_cmd.prev_addr = r_t;
                                thr_cmd.prev_d    = lvl_q.tail;
                            end else begin
                                lvl_cmd.head_we = 1'b1;
                                lvl_cmd.head_d  = r_t;
                            end
                            lvl_cmd.tail_we  = 1'b1;
                            lvl_cmd.tail_d   = r_t;
                            thr_cmd.lvl_we   = 1'b1;
                            thr_cmd.lvl_addr = r_t;
                            thr_cmd.lvl_d    = r_lvl;
                            n_queued[r_t]    = 1'b1;
                            n_bitmap         = r_bitmap | lvl_mask;
                        end else begin
                            if (lvl_q.head == r_t && lvl_q.tail == r_t) begin
                                n_bitmap = r_bitmap & ~lvl_mask;
                            end else if (lvl_q.head == r_t) begin
                                lvl_cmd.head_we = 1'b1;
                                lvl_cmd.head_d  = thr_q.next_link;
                            end else if (lvl_q.tail == r_t) begin
                                lvl_cmd.tail_we = 1'b1;
                                lvl_cmd.tail_d  = thr_q.prev_link;
                            end else begin
                                thr_cmd.next_we   = 1'b1;
                                thr_cmd.next_addr = thr_q.prev_link;
                                thr_cmd.next_d    = thr_q.next_link;
                                thr_cmd.prev_we   = 1'b1;
                                thr_cmd.prev_addr = thr_q.next_link;
                                thr_cmd.prev_d    = thr_q.prev_link;
                            end
                            n_queued[r_t] = 1'b0;
                        end
                    end
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_map    = n_bitmap;
                    if (!r_skip && r_op == prq_pkg::OP_DEQUEUE) begin
                        n_out_next = 8'(r_t);
                    end else begin
                        n_out_next = '0;
                    end
                    n_state = prq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = prq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_next_thread     = r_out_next;
    assign o_status          = r_out_status;
    assign o_levels_nonempty = prq_pkg::MAP_W'(r_out_map);

endmodule
